/* sv/lpr_pkg.sv */
package lpr_pkg;

  localparam int unsigned PAGE_W       = 16;
  localparam int unsigned NUM_FRAMES_W = 3;
  localparam int unsigned STAMP_W      = 32;
  localparam int unsigned FRAME_IDX_W  = 2;

  localparam logic [NUM_FRAMES_W-1:0] NUM_FRAMES_RST = 3'd4;
  localparam logic [STAMP_W-1:0]      STAMP_MAX      = '1;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic              last_ref;
  } in_req_t;

  typedef struct packed {
    logic                   hit;
    logic [FRAME_IDX_W-1:0] frame_index;
    logic [STAMP_W-1:0]     fault_total;
    logic                   sequence_done;
  } out_req_t;

  typedef struct packed {
    logic match;
    logic empty;
    logic less;
  } cmp_t;

endpackage

/* sv/lru_page_replacement.sv */
// channel   direction  handshake             payload
// in        input      in_valid / in_stall   in_data   (page, last_ref)
// out       output     out_valid / out_stall out_data  (hit, frame_index, fault_total, sequence_done)
// cfg       input      cfg_wr_en             cfg_wr_data (num_frames)
//
// a request is accepted, then each frame in use is checked in turn
// through the shared compare unit, then the update writes the frame table
// synchronous reset clears frame valid bits, stamps, counters; num_frames resets to 4
// the update cycle waits while a previous result is still held on out
// a new request is taken while a finished result waits on out
module lru_page_replacement #(
  parameter int FRAMES    = 4,
  parameter int PAGE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  lpr_pkg::in_req_t                     in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output lpr_pkg::out_req_t                    out_data,
  input  logic                                 cfg_wr_en,
  input  logic [lpr_pkg::NUM_FRAMES_W-1:0]     cfg_wr_data
);

  localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int PW    = (PAGE_BITS < 16) ? PAGE_BITS : 16;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_UPD  = 3'b100
  } state_t;

  state_t state;

  logic [lpr_pkg::NUM_FRAMES_W-1:0] num_frames;

  logic [PW-1:0]               frame_page  [FRAMES];
  logic [FRAMES-1:0]           frame_valid;
  logic [lpr_pkg::STAMP_W-1:0] frame_stamp [FRAMES];
  logic [lpr_pkg::STAMP_W-1:0] ref_index;
  logic [lpr_pkg::STAMP_W-1:0] fault_count;

  logic [PW-1:0]               key_page;
  logic                        key_last;
  logic [IDX_W-1:0]            idx;
  logic                        found;
  logic [IDX_W-1:0]            match_idx;
  logic                        empty_seen;
  logic [IDX_W-1:0]            empty_idx;
  logic [IDX_W-1:0]            best_idx;
  logic [lpr_pkg::STAMP_W-1:0] best_stamp;

  logic [IDX_W-1:0]            last_idx;
  lpr_pkg::cmp_t               cmp;
  logic                        in_acc;
  logic                        upd_go;
  logic [IDX_W-1:0]            used;
  logic [lpr_pkg::STAMP_W-1:0] fault_next;
  logic [31:0]                 used_wide;

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign upd_go   = (state == ST_UPD) && (!out_valid || !out_stall);

  always_comb begin
    if (num_frames == '0) begin
      last_idx = '0;
    end else if (32'(num_frames) > FRAMES) begin
      last_idx = IDX_W'(FRAMES - 1);
    end else begin
      last_idx = IDX_W'(num_frames - 3'd1);
    end
  end

  lpr_cmp #(
    .PW (PW)
  ) u_cmp (
    .entry_page  (frame_page[idx]),
    .entry_valid (frame_valid[idx]),
    .entry_stamp (frame_stamp[idx]),
    .key_page    (key_page),
    .best_stamp  (best_stamp),
    .first       (idx == '0),
    .res         (cmp)
  );

  always_comb begin
    if (found) begin
      used = match_idx;
    end else if (empty_seen) begin
      used = empty_idx;
    end else begin
      used = best_idx;
    end
    used_wide = 32'(used);
    if (!found && (fault_count != lpr_pkg::STAMP_MAX)) begin
      fault_next = fault_count + 32'd1;
    end else begin
      fault_next = fault_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_frames <= lpr_pkg::NUM_FRAMES_RST;
    end else if (cfg_wr_en) begin
      num_frames <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (idx == last_idx) begin
            state <= ST_UPD;
          end
        end
        ST_UPD: begin
          if (upd_go) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // key capture and scan bookkeeping
  always_ff @(posedge clk) begin
    if (in_acc) begin
      key_page   <= in_data.page[PW-1:0];
      key_last   <= in_data.last_ref;
      idx        <= '0;
      found      <= 1'b0;
      empty_seen <= 1'b0;
    end else if (state == ST_SCAN) begin
      if (cmp.match && !found) begin
        found     <= 1'b1;
        match_idx <= idx;
      end
      if (cmp.empty && !empty_seen) begin
        empty_seen <= 1'b1;
        empty_idx  <= idx;
      end
      if (cmp.less) begin
        best_idx   <= idx;
        best_stamp <= frame_stamp[idx];
      end
      if (idx != last_idx) begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd_go && !found) begin
      frame_page[used] <= key_page;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= '0;
      ref_index   <= '0;
      fault_count <= '0;
      for (int i = 0; i < FRAMES; i++) begin
        frame_stamp[i] <= '0;
      end
    end else if (upd_go) begin
      if (key_last) begin
        frame_valid <= '0;
        ref_index   <= '0;
        fault_count <= '0;
        for (int i = 0; i < FRAMES; i++) begin
          frame_stamp[i] <= '0;
        end
      end else begin
        frame_valid[used] <= 1'b1;
        frame_stamp[used] <= ref_index;
        fault_count       <= fault_next;
        if (ref_index != lpr_pkg::STAMP_MAX) begin
          ref_index <= ref_index + 32'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (upd_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_go) begin
      out_data.hit           <= found;
      out_data.frame_index   <= used_wide[lpr_pkg::FRAME_IDX_W-1:0];
      out_data.fault_total   <= fault_next;
      out_data.sequence_done <= key_last;
    end
  end

`ifndef NO_ASSERTIONS
  a_out_from_upd: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_UPD))
    else $error("result raised outside update");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (idx <= last_idx))
    else $error("scan index past frames in use");

  a_seq_clear: assert property (@(posedge clk) disable iff (rst)
    (upd_go && key_last) |=> (ref_index == '0 && fault_count == '0 && frame_valid == '0))
    else $error("sequence state not cleared");

  a_fault_le_ref: assert property (@(posedge clk) disable iff (rst)
    fault_count <= ref_index)
    else $error("fault count exceeds reference count");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> !$past(upd_go))
    else $error("result overwritten while held");
`endif

endmodule

/* sv/lpr_cmp.sv */
module lpr_cmp #(
  parameter int PW = 16
) (
  input  logic [PW-1:0]                   entry_page,
  input  logic                            entry_valid,
  input  logic [lpr_pkg::STAMP_W-1:0]     entry_stamp,
  input  logic [PW-1:0]                   key_page,
  input  logic [lpr_pkg::STAMP_W-1:0]     best_stamp,
  input  logic                            first,
  output lpr_pkg::cmp_t                   res
);

  assign res.match = entry_valid && (entry_page == key_page);
  assign res.empty = !entry_valid;
  assign res.less  = first || (entry_stamp < best_stamp);

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps
module tb;

  localparam int FRAMES = 4;
  localparam int RANDOM_REFS = 650;
  localparam int PAGE_W = lpr_pkg::PAGE_W;
  localparam int NUM_FRAMES_W = lpr_pkg::NUM_FRAMES_W;
  localparam int STAMP_W = lpr_pkg::STAMP_W;
  localparam int FRAME_IDX_W = lpr_pkg::FRAME_IDX_W;

  typedef struct {
    bit                      do_cfg;
    logic [NUM_FRAMES_W-1:0] cfg;
    lpr_pkg::in_req_t        req;
    bit                      typed;
    lpr_pkg::out_req_t       want;
  } dir_row_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  lpr_pkg::in_req_t        in_data = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  lpr_pkg::out_req_t       out_data;
  logic                    cfg_wr_en = 1'b0;
  logic [NUM_FRAMES_W-1:0] cfg_wr_data = '0;

  // frame table mirror
  logic [PAGE_W-1:0]       tag_page [FRAMES];
  bit                      tag_live [FRAMES];
  logic [STAMP_W-1:0]      tag_used_at [FRAMES];
  logic [STAMP_W-1:0]      ref_count;
  logic [STAMP_W-1:0]      miss_count;
  logic [NUM_FRAMES_W-1:0] cfg_frames;

  lpr_pkg::out_req_t lookups_due [$];
  lpr_pkg::out_req_t due_head;
  dir_row_t dir_rows [$];
  int       bad_lookups = 0;
  int       stall_left = 0;
  bit       rx_calm = 1'b0;

  lru_page_replacement #(
    .FRAMES(FRAMES),
    .PAGE_BITS(PAGE_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  function automatic void lru_clear();
    for (int k = 0; k < FRAMES; k++) begin
      tag_page[k] = '0;
      tag_live[k] = 1'b0;
      tag_used_at[k] = '0;
    end
    ref_count = '0;
    miss_count = '0;
  endfunction

  function automatic lpr_pkg::out_req_t lru_lookup(lpr_pkg::in_req_t req);
    int                n;
    int                slot;
    bit                found;
    bit                empty;
    lpr_pkg::out_req_t res;
    n = (cfg_frames == 0) ? 1 : (cfg_frames > FRAMES) ? FRAMES : int'(cfg_frames);
    found = 1'b0;
    empty = 1'b0;
    slot = 0;
    for (int k = 0; k < n; k++) begin
      if (!found && tag_live[k] && tag_page[k] == req.page) begin
        slot = k;
        found = 1'b1;
      end
    end
    if (!found) begin
      if (miss_count != lpr_pkg::STAMP_MAX) miss_count++;
      for (int k = 0; k < n; k++) begin
        if (!empty && !tag_live[k]) begin
          slot = k;
          empty = 1'b1;
        end
      end
      if (!empty) begin
        slot = 0;
        for (int k = 1; k < n; k++) begin
          if (tag_used_at[k] < tag_used_at[slot]) slot = k;
        end
      end
      tag_page[slot] = req.page;
      tag_live[slot] = 1'b1;
    end
    tag_used_at[slot] = ref_count;
    if (ref_count != lpr_pkg::STAMP_MAX) ref_count++;
    res.hit = found;
    res.frame_index = FRAME_IDX_W'(slot);
    res.fault_total = miss_count;
    res.sequence_done = req.last_ref;
    if (req.last_ref) lru_clear();
    return res;
  endfunction

  function automatic dir_row_t mk_row(int do_cfg, int cfg,
                                      logic [PAGE_W-1:0] page, int last, int typed,
                                      int hit, int frame, int total);
    dir_row_t r;
    r.do_cfg = (do_cfg != 0);
    r.cfg = NUM_FRAMES_W'(cfg);
    r.req.page = page;
    r.req.last_ref = (last != 0);
    r.typed = (typed != 0);
    r.want.hit = (hit != 0);
    r.want.frame_index = FRAME_IDX_W'(frame);
    r.want.fault_total = STAMP_W'(total);
    r.want.sequence_done = (last != 0);
    return r;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(1, 3);
    if (r < 19) return $urandom_range(4, 8);
    return $urandom_range(10, 40);
  endfunction

  function automatic int tx_gap(bit calm);
    if (calm || $urandom_range(0, 1) == 0) return 0;
    return idle_len();
  endfunction

  task automatic send_ref(input lpr_pkg::in_req_t req, input bit typed,
                          input lpr_pkg::out_req_t want, input int gap);
    lpr_pkg::out_req_t res;
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    res = lru_lookup(req);
    lookups_due.push_back(typed ? want : res);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (lookups_due.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [NUM_FRAMES_W-1:0] value);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cfg_frames = value;
  endtask

  // result stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if (!rx_calm && $urandom_range(0, 3) == 0) stall_left = idle_len();
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (lookups_due.size() == 0) begin
        bad_lookups++;
        if (bad_lookups <= 10)
          $display("unexpected result: hit=%0b frame=%0d faults=%0d done=%0b",
                   out_data.hit, out_data.frame_index, out_data.fault_total,
                   out_data.sequence_done);
      end else begin
        due_head = lookups_due.pop_front();
        if (out_data.hit !== due_head.hit ||
            out_data.frame_index !== due_head.frame_index ||
            out_data.fault_total !== due_head.fault_total ||
            out_data.sequence_done !== due_head.sequence_done) begin
          bad_lookups++;
          if (bad_lookups <= 10)
            $display("mismatch: want %0b %0d %0d %0b, got %0b %0d %0d %0b",
                     due_head.hit, due_head.frame_index, due_head.fault_total,
                     due_head.sequence_done, out_data.hit, out_data.frame_index,
                     out_data.fault_total, out_data.sequence_done);
        end
      end
    end
  end

  initial begin
    int                 sent;
    int                 phase;
    int                 len;
    int                 pool_n;
    bit                 calm;
    logic [PAGE_W-1:0]  pool [8];
    lpr_pkg::in_req_t   req;
    lpr_pkg::out_req_t  none;
    lru_clear();
    cfg_frames = lpr_pkg::NUM_FRAMES_RST;
    none = '0;

    // reset frame count
    dir_rows.push_back(mk_row(0, 0, 16'h0000, 0, 1, 0, 0, 1));
    dir_rows.push_back(mk_row(0, 0, 16'hffff, 0, 1, 0, 1, 2));
    dir_rows.push_back(mk_row(0, 0, 16'h0000, 0, 1, 1, 0, 2));
    dir_rows.push_back(mk_row(0, 0, 16'h1234, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(0, 0, 16'h5678, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(0, 0, 16'habcd, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(0, 0, 16'hffff, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(0, 0, 16'h1234, 1, 0, 0, 0, 0));
    // stale pages gone after end of sequence
    dir_rows.push_back(mk_row(0, 0, 16'h1234, 0, 1, 0, 0, 1));
    dir_rows.push_back(mk_row(0, 0, 16'h1234, 1, 1, 1, 0, 1));
    // zero frames acts as one
    dir_rows.push_back(mk_row(1, 0, 16'h0001, 0, 1, 0, 0, 1));
    dir_rows.push_back(mk_row(0, 0, 16'h0002, 0, 1, 0, 0, 2));
    dir_rows.push_back(mk_row(0, 0, 16'h0002, 0, 1, 1, 0, 2));
    // count changes inside a sequence
    dir_rows.push_back(mk_row(1, 7, 16'h0003, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(0, 0, 16'h0002, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(1, 2, 16'h0009, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(1, 4, 16'h0003, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(0, 0, 16'h0004, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(0, 0, 16'h0005, 0, 0, 0, 0, 0));
    // page 5 hit with one frame in use, then hit again with four
    dir_rows.push_back(mk_row(1, 1, 16'h0005, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(1, 4, 16'h0005, 1, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(1, 3, 16'h8000, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(0, 0, 16'h7fff, 1, 0, 0, 0, 0));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].do_cfg) cfg_write(dir_rows[i].cfg);
      send_ref(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want, tx_gap(1'b0));
    end

    sent = 0;
    phase = 0;
    while (sent < RANDOM_REFS) begin
      cfg_write((phase < 8) ? NUM_FRAMES_W'((phase * 5 + 1) % 8)
                            : NUM_FRAMES_W'($urandom_range(0, 7)));
      calm = ($urandom_range(0, 3) == 0);
      rx_calm <= calm;
      len = $urandom_range(15, 60);
      pool_n = $urandom_range(2, 8);
      for (int k = 0; k < 8; k++) pool[k] = PAGE_W'($urandom);
      if ($urandom_range(0, 1) == 0) pool[0] = '0;
      if ($urandom_range(0, 1) == 0) pool[1] = '1;
      for (int j = 0; j < len; j++) begin
        if ($urandom_range(0, 9) < 7) req.page = pool[3'($urandom_range(0, pool_n - 1))];
        else req.page = PAGE_W'($urandom);
        req.last_ref = ($urandom_range(0, 24) == 0);
        send_ref(req, 1'b0, none, tx_gap(calm));
        sent++;
      end
      phase++;
    end

    drain();
    repeat (20) @(posedge clk);
    if (bad_lookups == 0) begin
      $display("lru_page_replacement test passed");
    end else begin
      $display("lru_page_replacement test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("lru_page_replacement test failed");
    $finish;
  end

endmodule
